[rtl/core/wang_landau_histogram_update_assert.svh]
// assertion macros for the wang-landau histogram update checker
// depends on nothing; taken in by the checker file
`ifndef WANG_LANDAU_HISTOGRAM_UPDATE_ASSERT_SVH
`define WANG_LANDAU_HISTOGRAM_UPDATE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WLHU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define WLHU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/wlhu_pkg.sv]
// shared types and constants of the wang-landau histogram update
// no dependencies
package wlhu_pkg;

  localparam int NUM_BINS_DEF      = 128;
  localparam int LOG_FRAC_BITS_DEF = 24;
  localparam int COUNT_WIDTH_DEF   = 32;

  localparam int LD_W       = 40;  // log density word
  localparam int TOTAL_W    = 32;  // accepted-move count
  localparam int RAND_FRAC  = 24;  // fraction bits of the random term
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FLAT_BINS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_STAGE = 8'd1;

  localparam logic [7:0] FLAT_BINS_RST  = 8'd80;
  localparam logic [4:0] LAST_STAGE_RST = 5'd17;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RDLO, S_RDHI, S_CMP, S_VRD, S_VWR,
    S_SCAN, S_CHECK, S_MIN, S_SUB, S_OUT
  } state_t;

endpackage

[rtl/core/wang_landau_histogram_update.sv]
// wang-landau histogram update core; depends on wlhu_pkg and wlhu_ram
// a rejected step runs RDLO, RDHI, CMP, VRD, VWR, CHECK and OUT; an accepted one adds SCAN after
// VWR (the first beat skips RDLO, RDHI and CMP); closing a stage adds MIN and SUB after CHECK;
// a finished beat goes straight to OUT; a new beat is taken only in IDLE; the single read port
// of the bin memories sets the scans; reset: synchronous active-low; a clearing pass zeroes both
// memories before the first input beat is taken; config writes are taken always
module wang_landau_histogram_update #(
  parameter int NUM_BINS      = wlhu_pkg::NUM_BINS_DEF,
  parameter int LOG_FRAC_BITS = wlhu_pkg::LOG_FRAC_BITS_DEF,
  parameter int COUNT_WIDTH   = wlhu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // quality [15:0], neg_log_uniform [47:16]
  input  logic [47:0]                    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // accepted [0], current_bin [7:1], flat_score [15:8], stage_number [20:16],
  // stage_done [21], all_finished [22], zero [23]
  output logic [23:0]                    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wlhu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlhu_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int PTR_W = $clog2(NUM_BINS + 1);
  localparam int MAP_W = 16 + BIN_W + 2;
  localparam int LD_W  = wlhu_pkg::LD_W;
  localparam int TW    = wlhu_pkg::TOTAL_W;
  localparam int MW    = COUNT_WIDTH + PTR_W + TW;
  localparam int CW_W  = LD_W + 32;
  localparam int SH_UP = (LOG_FRAC_BITS >= wlhu_pkg::RAND_FRAC) ?
                         LOG_FRAC_BITS - wlhu_pkg::RAND_FRAC : 0;
  localparam int SH_DN = (LOG_FRAC_BITS < wlhu_pkg::RAND_FRAC) ?
                         wlhu_pkg::RAND_FRAC - LOG_FRAC_BITS : 0;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [LD_W-1:0]        LD_MAX  = '1;
  localparam logic [TW-1:0]          TOT_MAX = '1;

  // sequencer and datapath registers
  wlhu_pkg::state_t state_r, state_nxt;
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;
  logic                   sv_r, sv_nxt;        // read data of a scan is valid
  logic [BIN_W-1:0]       waddr_r, waddr_nxt;  // address behind the read data
  logic [BIN_W-1:0]       bin_r, bin_nxt;
  logic [31:0]            rnd_r, rnd_nxt;
  logic [LD_W-1:0]        lo_r, lo_nxt;
  logic [LD_W-1:0]        min_r, min_nxt;
  logic [BIN_W-1:0]       present_r, present_nxt;
  logic                   have_r, have_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic [7:0]             score_r, score_nxt;
  logic [7:0]             sacc_r, sacc_nxt;
  logic [4:0]             stage_r, stage_nxt;
  logic                   done_r, done_nxt;
  logic                   acc_r, acc_nxt;
  logic                   sdone_r, sdone_nxt;
  logic [7:0]             fbn_r, fbn_nxt;
  logic [4:0]             last_r, last_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [23:0]            out_tdata_r, out_tdata_nxt;

  // memory ports, both memories share the addresses
  logic                   we;
  logic [BIN_W-1:0]       waddr, raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic [LD_W-1:0]        ld_wdata, ld_rdata;

  wlhu_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_cnt_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(cnt_wdata),
    .raddr(raddr), .rdata(cnt_rdata)
  );

  wlhu_ram #(.WIDTH(LD_W), .DEPTH(NUM_BINS)) u_ld_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ld_wdata),
    .raddr(raddr), .rdata(ld_rdata)
  );

  // bin of the incoming quality, saturated at the top bin
  logic [MAP_W-1:0] map_prod;
  logic [MAP_W-1:0] map_bin;
  logic [BIN_W-1:0] in_bin;
  assign map_prod = MAP_W'(in_tdata[15:0]) * MAP_W'(2 * NUM_BINS);
  assign map_bin  = map_prod >> 16;
  assign in_bin   = (map_bin > MAP_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                      : BIN_W'(map_bin);

  // stage increment 2^(LOG_FRAC_BITS - stage), zero past the fraction
  logic [LD_W-1:0] inc;
  assign inc = (32'(stage_r) > 32'(LOG_FRAC_BITS)) ? '0
             : (LD_W'(1) << (LOG_FRAC_BITS - int'(stage_r)));

  logic [LD_W:0]   ld_sum;
  logic [LD_W-1:0] diff;
  logic            move_ok;
  logic            scan_end;
  logic [MW-1:0]   cnt_scaled;
  logic [4:0]      stage_inc;

  assign ld_sum     = {1'b0, ld_rdata} + {1'b0, inc};
  assign diff       = ld_rdata - lo_r;
  // accept when the density does not rise or the rise stays below -ln(u)
  assign move_ok    = (ld_rdata <= lo_r) ||
                      ((CW_W'(diff) << SH_DN) < (CW_W'(rnd_r) << SH_UP));
  assign scan_end   = (ptr_r == PTR_W'(NUM_BINS)) && !sv_r;
  assign cnt_scaled = MW'(cnt_rdata) * MW'(NUM_BINS);
  assign stage_inc  = (stage_r == 5'd31) ? stage_r : stage_r + 5'd1;

  assign in_tready  = (state_r == wlhu_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wlhu_pkg::S_INIT;
      ptr_r        <= '0;
      sv_r         <= 1'b0;
      present_r    <= '0;
      have_r       <= 1'b0;
      total_r      <= '0;
      score_r      <= '0;
      stage_r      <= '0;
      done_r       <= 1'b0;
      fbn_r        <= wlhu_pkg::FLAT_BINS_RST;
      last_r       <= wlhu_pkg::LAST_STAGE_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      sv_r         <= sv_nxt;
      present_r    <= present_nxt;
      have_r       <= have_nxt;
      total_r      <= total_nxt;
      score_r      <= score_nxt;
      stage_r      <= stage_nxt;
      done_r       <= done_nxt;
      fbn_r        <= fbn_nxt;
      last_r       <= last_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    waddr_r     <= waddr_nxt;
    bin_r       <= bin_nxt;
    rnd_r       <= rnd_nxt;
    lo_r        <= lo_nxt;
    min_r       <= min_nxt;
    sacc_r      <= sacc_nxt;
    acc_r       <= acc_nxt;
    sdone_r     <= sdone_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    sv_nxt         = sv_r;
    waddr_nxt      = waddr_r;
    bin_nxt        = bin_r;
    rnd_nxt        = rnd_r;
    lo_nxt         = lo_r;
    min_nxt        = min_r;
    present_nxt    = present_r;
    have_nxt       = have_r;
    total_nxt      = total_r;
    score_nxt      = score_r;
    sacc_nxt       = sacc_r;
    stage_nxt      = stage_r;
    done_nxt       = done_r;
    acc_nxt        = acc_r;
    sdone_nxt      = sdone_r;
    fbn_nxt        = fbn_r;
    last_nxt       = last_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    we             = 1'b0;
    waddr          = present_r;
    raddr          = present_r;
    cnt_wdata      = '0;
    ld_wdata       = '0;

    // config beats land at once
    if (cfg_valid) begin
      if (cfg_index == wlhu_pkg::REG_FLAT_BINS) begin
        fbn_nxt = cfg_data;
      end else if (cfg_index == wlhu_pkg::REG_LAST_STAGE) begin
        last_nxt = cfg_data[4:0];
      end
    end

    unique case (state_r)
      // clearing pass after reset
      wlhu_pkg::S_INIT: begin
        we      = 1'b1;
        waddr   = ptr_r[BIN_W-1:0];
        ptr_nxt = ptr_r + PTR_W'(1);
        if (ptr_r == PTR_W'(NUM_BINS - 1)) begin
          state_nxt = wlhu_pkg::S_IDLE;
        end
      end
      wlhu_pkg::S_IDLE: begin
        if (in_tvalid) begin
          bin_nxt   = in_bin;
          rnd_nxt   = in_tdata[47:16];
          acc_nxt   = 1'b0;
          sdone_nxt = 1'b0;
          if (done_r || (stage_r >= last_r)) begin
            // finished: the beat only reports
            done_nxt  = 1'b1;
            state_nxt = wlhu_pkg::S_OUT;
          end else if (!have_r) begin
            // first beat takes its bin with no test
            have_nxt    = 1'b1;
            present_nxt = in_bin;
            acc_nxt     = 1'b1;
            state_nxt   = wlhu_pkg::S_VRD;
          end else begin
            state_nxt = wlhu_pkg::S_RDLO;
          end
        end
      end
      wlhu_pkg::S_RDLO: begin
        raddr     = present_r;
        state_nxt = wlhu_pkg::S_RDHI;
      end
      wlhu_pkg::S_RDHI: begin
        raddr     = bin_r;
        lo_nxt    = ld_rdata;
        state_nxt = wlhu_pkg::S_CMP;
      end
      wlhu_pkg::S_CMP: begin
        if (move_ok) begin
          present_nxt = bin_r;
          acc_nxt     = 1'b1;
        end
        state_nxt = wlhu_pkg::S_VRD;
      end
      // visit the occupied bin
      wlhu_pkg::S_VRD: begin
        raddr     = present_r;
        state_nxt = wlhu_pkg::S_VWR;
      end
      wlhu_pkg::S_VWR: begin
        we        = 1'b1;
        waddr     = present_r;
        cnt_wdata = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1);
        ld_wdata  = ld_sum[LD_W] ? LD_MAX : ld_sum[LD_W-1:0];
        if (acc_r) begin
          if (total_r != TOT_MAX) begin
            total_nxt = total_r + TW'(1);
          end
          ptr_nxt   = '0;
          sv_nxt    = 1'b0;
          sacc_nxt  = '0;
          state_nxt = wlhu_pkg::S_SCAN;
        end else begin
          state_nxt = wlhu_pkg::S_CHECK;
        end
      end
      // flatness score over all counts, one bin a cycle
      wlhu_pkg::S_SCAN: begin
        raddr  = ptr_r[BIN_W-1:0];
        sv_nxt = (ptr_r < PTR_W'(NUM_BINS));
        if (ptr_r < PTR_W'(NUM_BINS)) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
        if (sv_r && (cnt_scaled > MW'(total_r)) && (sacc_r != 8'hFF)) begin
          sacc_nxt = sacc_r + 8'd1;
        end
        if (scan_end) begin
          score_nxt = sacc_r;
          state_nxt = wlhu_pkg::S_CHECK;
        end
      end
      wlhu_pkg::S_CHECK: begin
        if (score_r >= fbn_r) begin
          ptr_nxt   = '0;
          sv_nxt    = 1'b0;
          min_nxt   = LD_MAX;
          state_nxt = wlhu_pkg::S_MIN;
        end else begin
          state_nxt = wlhu_pkg::S_OUT;
        end
      end
      // minimum log density
      wlhu_pkg::S_MIN: begin
        raddr  = ptr_r[BIN_W-1:0];
        sv_nxt = (ptr_r < PTR_W'(NUM_BINS));
        if (ptr_r < PTR_W'(NUM_BINS)) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
        if (sv_r && (ld_rdata < min_r)) begin
          min_nxt = ld_rdata;
        end
        if (scan_end) begin
          ptr_nxt   = '0;
          sv_nxt    = 1'b0;
          state_nxt = wlhu_pkg::S_SUB;
        end
      end
      // subtract the minimum and clear the counts, read one ahead of the write
      wlhu_pkg::S_SUB: begin
        raddr     = ptr_r[BIN_W-1:0];
        waddr_nxt = ptr_r[BIN_W-1:0];
        sv_nxt    = (ptr_r < PTR_W'(NUM_BINS));
        if (ptr_r < PTR_W'(NUM_BINS)) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
        if (sv_r) begin
          we        = 1'b1;
          waddr     = waddr_r;
          cnt_wdata = '0;
          ld_wdata  = ld_rdata - min_r;
        end
        if (scan_end) begin
          total_nxt = '0;
          score_nxt = '0;
          stage_nxt = stage_inc;
          sdone_nxt = 1'b1;
          if (stage_inc >= last_r) begin
            done_nxt = 1'b1;
          end
          state_nxt = wlhu_pkg::S_OUT;
        end
      end
      // hand the result to the output register once it is free
      wlhu_pkg::S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, done_r, sdone_r, stage_r, score_r,
                            7'(present_r), acc_r};
          state_nxt      = wlhu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wlhu_pkg::S_IDLE;
      end
    endcase
  end
endmodule

[rtl/core/wlhu_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module wlhu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[rtl/core/wlhu_checker.sv]
// port-level checker for the wang-landau histogram update, bound to the top level
// depends on wang_landau_histogram_update_assert.svh
`include "wang_landau_histogram_update_assert.svh"

module wlhu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  logic out_beat;
  logic fin_seen_r;

  assign out_beat = out_tvalid && out_tready;

  // once a result reports finished, every later one does too
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_seen_r <= 1'b0;
    end else if (out_beat && out_tdata[22]) begin
      fin_seen_r <= 1'b1;
    end
  end

  `WLHU_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `WLHU_ASSERT_NOW(a_fin_sticky, clk, rst_n, out_tvalid && fin_seen_r, out_tdata[22])
  `WLHU_ASSERT_NOW(a_close_clears_score, clk, rst_n, out_tvalid && out_tdata[21],
                   out_tdata[15:8] == 8'd0)
  `WLHU_ASSERT_NEXT(a_out_holds, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))
endmodule

bind wang_landau_histogram_update wlhu_checker u_wlhu_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
